// ----- sv/decimal_digit_substring_filter_macros.svh -----
// Assertion helpers for the digit substring filter.
// Define NO_ASSERTIONS to compile them away.
`ifndef DECIMAL_DIGIT_SUBSTRING_FILTER_MACROS_SVH
`define DECIMAL_DIGIT_SUBSTRING_FILTER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define DDSF_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define DDSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DDSF_ASSERT_HOLDS(label, clk, rst, ante, cons)
`define DDSF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/ddsf_pkg.sv -----
`default_nettype none
package ddsf_pkg;

   // default identifier width
   localparam int DEFAULT_WORD_WIDTH = 32;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // register index of the search key (selected by one address bit)
   localparam logic CSR_KEY_INDEX = 1'b0;

   // decimal digits needed for the largest value of a width-bit word
   function automatic int digit_count(input int width);
      return (width * 30103) / 100000 + 1;
   endfunction

   // control from the front queue to the back
   typedef struct packed {
      logic valid;
      logic bypass;   // key was zero when the item came in: always passes
   } item_ctl_type;

endpackage
`default_nettype wire

// ----- sv/decimal_digit_substring_filter.sv -----
// Decimal digit substring filter.
// Input queue (req_): push an identifier while req_full is low; it is
// transferred at a clock edge with req_push high and req_full low.
// Result queue (rsp_): while rsp_empty is low the oldest passing identifier
// is on rsp_matched_number; it is transferred when rsp_pop is high.
// An identifier passes when the decimal digits of search_key appear as a
// contiguous run in its own digits; a zero key passes everything.
// Config (csr_): APB-style, search_key at byte address 0, pready tied high.
// Timing: each identifier is converted to decimal by a one-bit-per-cycle
// shift-and-add-3 unit; in the back an item goes through take, WORD_WIDTH
// conversion steps, and compare and emit; with a zero key it goes through
// take and emit only. After a key write the same unit converts the key once
// before the next identifier starts.
// A two-entry queue buffers input while the back is busy; a held result
// stalls only the compare step, the queue keeps filling until full.
// Reset empties both queues and sets the key to zero.
`default_nettype none
module decimal_digit_substring_filter #(
   parameter int WORD_WIDTH = ddsf_pkg::DEFAULT_WORD_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [WORD_WIDTH-1:0]                  req_candidate_number,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [WORD_WIDTH-1:0]                  rsp_matched_number,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [((WORD_WIDTH > 32) ? 4 : 3)-1:0] csr_paddr,
   input  logic [((WORD_WIDTH > 32) ? 64 : 32)-1:0] csr_pwdata,
   output logic [((WORD_WIDTH > 32) ? 64 : 32)-1:0] csr_prdata,
   output logic                                   csr_pready
);
   import ddsf_pkg::*;

   localparam int DATA_W = (WORD_WIDTH > 32) ? 64 : 32;
   localparam int ADDR_W = (WORD_WIDTH > 32) ? 4 : 3;

   logic [WORD_WIDTH-1:0] key_ff, key_in;
   logic                  key_write;
   item_ctl_type          item_ctl;
   logic [WORD_WIDTH-1:0] item_data;
   logic                  item_take;
   logic                  res_valid;

   // register file: one key register
   assign csr_pready = 1'b1;
   assign key_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[ADDR_W-1] == CSR_KEY_INDEX);
   assign key_in     = key_write ? csr_pwdata[WORD_WIDTH-1:0] : key_ff;
   assign csr_prdata = (csr_paddr[ADDR_W-1] == CSR_KEY_INDEX) ? DATA_W'(key_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // input queue and classification
   ddsf_front #(
      .WORD_WIDTH (WORD_WIDTH),
      .DEPTH      (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .push_data   (req_candidate_number),
      .key_is_zero (key_ff == '0),
      .item_ctl    (item_ctl),
      .item_data   (item_data),
      .item_take   (item_take)
   );

   // conversion, compare and result register
   ddsf_back #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .key_write (key_write),
      .key       (key_ff),
      .item_ctl  (item_ctl),
      .item_data (item_data),
      .item_take (item_take),
      .res_valid (res_valid),
      .res_pop   (rsp_pop),
      .res_data  (rsp_matched_number)
   );

   assign rsp_empty = !res_valid;

endmodule
`default_nettype wire

// ----- sv/ddsf_front.sv -----
`default_nettype none
module ddsf_front #(
   parameter int WORD_WIDTH = ddsf_pkg::DEFAULT_WORD_WIDTH,
   parameter int DEPTH      = ddsf_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [WORD_WIDTH-1:0]   push_data,
   input  logic                    key_is_zero,
   output ddsf_pkg::item_ctl_type  item_ctl,
   output logic [WORD_WIDTH-1:0]   item_data,
   input  logic                    item_take
);
   import ddsf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WORD_WIDTH-1:0] data_ff [DEPTH];
   logic                  bypass_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  wr_en, rd_en;

   // handshake status
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign wr_en = push && !full;
   assign rd_en = item_take && (count_ff != '0);

   // oldest entry goes to the back
   assign item_ctl.valid  = (count_ff != '0);
   assign item_ctl.bypass = bypass_ff[rd_ptr_ff];
   assign item_data       = data_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // classify on entry and store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         data_ff[wr_ptr_ff]   <= push_data;
         bypass_ff[wr_ptr_ff] <= key_is_zero;
      end
   end

endmodule
`default_nettype wire

// ----- sv/ddsf_back.sv -----
`default_nettype none
`include "decimal_digit_substring_filter_macros.svh"
module ddsf_back #(
   parameter int WORD_WIDTH = ddsf_pkg::DEFAULT_WORD_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    key_write,
   input  logic [WORD_WIDTH-1:0]   key,
   input  ddsf_pkg::item_ctl_type  item_ctl,
   input  logic [WORD_WIDTH-1:0]   item_data,
   output logic                    item_take,
   output logic                    res_valid,
   input  logic                    res_pop,
   output logic [WORD_WIDTH-1:0]   res_data
);
   import ddsf_pkg::*;

   localparam int NDIG     = digit_count(WORD_WIDTH);
   localparam int BCD_BITS = 4 * NDIG;
   localparam int CNT_W    = $clog2(WORD_WIDTH);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_WIDTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_KEY  = 4'b0010,
      ST_CAND = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [WORD_WIDTH-1:0] shift_ff, shift_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]   key_bcd_ff, key_bcd_in;
   logic [NDIG-1:0]       key_used_ff, key_used_in;
   logic                  stale_ff, stale_in;
   logic                  bypass_ff, bypass_in;
   logic [WORD_WIDTH-1:0] cand_ff, cand_in;
   logic                  res_valid_ff, res_valid_in;
   logic [WORD_WIDTH-1:0] res_data_ff, res_data_in;

   logic [BCD_BITS-1:0]   adj;
   logic [BCD_BITS-1:0]   bcd_step;
   logic [NDIG-1:0]       used_step;
   logic                  window_hit;
   logic                  emit_ready;

   // one double-dabble step: add 3 to digits of 5 and up, shift in next bit
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                     : bcd_ff[i*4 +: 4];
      end
      bcd_step = {adj[BCD_BITS-2:0], shift_ff[WORD_WIDTH-1]};
   end

   // key digit positions at or below the leading nonzero digit
   always_comb begin
      used_step[NDIG-1] = |bcd_step[(NDIG-1)*4 +: 4];
      for (int j = NDIG - 2; j >= 0; j--) begin
         used_step[j] = used_step[j+1] | (|bcd_step[j*4 +: 4]);
      end
   end

   // key digits against every window of candidate digits; digits past the top are zero
   always_comb begin
      logic       hit_k;
      logic [3:0] cand_digit;
      window_hit = 1'b0;
      for (int k = 0; k < NDIG; k++) begin
         hit_k = 1'b1;
         for (int j = 0; j < NDIG; j++) begin
            if (k + j < NDIG) begin
               cand_digit = bcd_ff[(k+j)*4 +: 4];
            end else begin
               cand_digit = 4'd0;
            end
            if (key_used_ff[j] && (cand_digit != key_bcd_ff[j*4 +: 4])) begin
               hit_k = 1'b0;
            end
         end
         window_hit = window_hit | hit_k;
      end
   end

   assign emit_ready = !res_valid_ff || res_pop;

   // sequencer: key conversion, candidate conversion, result
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      shift_in     = shift_ff;
      bcd_in       = bcd_ff;
      key_bcd_in   = key_bcd_ff;
      key_used_in  = key_used_ff;
      stale_in     = stale_ff;
      bypass_in    = bypass_ff;
      cand_in      = cand_ff;
      res_valid_in = res_valid_ff && !res_pop;
      res_data_in  = res_data_ff;
      item_take    = 1'b0;
      if (key_write) begin
         stale_in = 1'b1;
         state_in = ST_IDLE;
         cnt_in   = '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (stale_ff) begin
                  stale_in = 1'b0;
                  shift_in = key;
                  bcd_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_KEY;
               end else if (item_ctl.valid) begin
                  item_take = 1'b1;
                  cand_in   = item_data;
                  shift_in  = item_data;
                  bcd_in    = '0;
                  bypass_in = item_ctl.bypass;
                  state_in  = item_ctl.bypass ? ST_EMIT : ST_CAND;
               end
            end
            ST_KEY: begin
               bcd_in   = bcd_step;
               shift_in = {shift_ff[WORD_WIDTH-2:0], 1'b0};
               if (cnt_ff == LAST) begin
                  key_bcd_in  = bcd_step;
                  key_used_in = used_step;
                  cnt_in      = '0;
                  state_in    = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            ST_CAND: begin
               bcd_in   = bcd_step;
               shift_in = {shift_ff[WORD_WIDTH-2:0], 1'b0};
               if (cnt_ff == LAST) begin
                  cnt_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            ST_EMIT: begin
               if (emit_ready) begin
                  if (bypass_ff || window_hit) begin
                     res_valid_in = 1'b1;
                     res_data_in  = cand_ff;
                  end
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         stale_ff     <= 1'b0;
         key_used_ff  <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         stale_ff     <= stale_in;
         key_used_ff  <= key_used_in;
         res_valid_ff <= res_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      bcd_ff      <= bcd_in;
      key_bcd_ff  <= key_bcd_in;
      bypass_ff   <= bypass_in;
      cand_ff     <= cand_in;
      res_data_ff <= res_data_in;
   end

   assign res_valid = res_valid_ff;
   assign res_data  = res_data_ff;

   // checks
   `DDSF_ASSERT_NEXT(a_cand_done_to_emit, clock, reset, state_ff == ST_CAND && cnt_ff == LAST && !key_write, state_ff == ST_EMIT)
   `DDSF_ASSERT_HOLDS(a_result_from_emit, clock, reset, $rose(res_valid_ff), $past(state_ff == ST_EMIT))
   `DDSF_ASSERT_HOLDS(a_idle_count_clear, clock, reset, state_ff == ST_IDLE, cnt_ff == '0)

endmodule
`default_nettype wire
